// ===== design/asc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

    // Initial value of lane 0 for Ascon-128
    localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;

    // Round counts: full permutation and the per-block permutation
    localparam int unsigned ROUNDS_A = 12;
    localparam int unsigned ROUNDS_B = 6;

    // Bytes in one full message block
    localparam logic [3:0] BLOCK_BYTES = 4'd8;

    // Padding byte after the last message byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [4:0][63:0] t_lanes;

    // Input word kinds
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_BLOCK = 1'b1
    } t_in_kind;

    // Output word kinds
    typedef enum logic {
        OUT_CT  = 1'b0,
        OUT_TAG = 1'b1
    } t_out_kind;

    // Configuration register indexes
    typedef enum logic {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic        kind;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] block;
        logic [3:0]  block_bytes;
    } t_in_word;

    typedef struct packed {
        logic        out_kind;
        logic [63:0] data;
        logic [3:0]  data_bytes;
        logic        last;
    } t_out_word;

    // Mask covering the first len bytes (top bits first), len 0..8
    function automatic logic [63:0] asc_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) < len) begin
                m[63 - 8*j -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // Padding byte placed right after the first len bytes, none for len 8
    function automatic logic [63:0] asc_pad(input logic [3:0] len);
        logic [63:0] p;
        p = '0;
        for (int j = 0; j < 8; j++) begin
            if (4'(j) == len) begin
                p[63 - 8*j -: 8] = PAD_BYTE;
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== design/ascon128_aead_encrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ascon-128 encryption with empty associated data. Write the key through the
// config port, send a start word with the nonce, then message words of 8
// bytes; a word with 0 to 7 bytes is the final one and is followed by two
// tag words, the second marked last. Blocks sent with no message open are
// dropped. One shared round unit runs one permutation round per clock; a start
// word runs the full permutation, a full block is emitted and then runs the
// per-block rounds, and a final block is emitted, runs the full permutation
// and emits both tag words. The input is stalled while a word is worked on;
// one output register lets a finished word wait while the next input is taken.
module ascon128_aead_encrypt
    import asc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_word    i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_word        o_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EMIT = 5'b00010,
        S_PERM = 5'b00100,
        S_TAG0 = 5'b01000,
        S_TAG1 = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_BLOCK = 2'd1,
        MODE_FINAL = 2'd2
    } t_mode;

    localparam logic [3:0] LAST_ROUND  = 4'(ROUNDS_A - 1);
    localparam logic [3:0] FIRST_BLOCK = 4'(ROUNDS_A - ROUNDS_B);

    t_state      r_state, n_state;
    t_mode       r_mode, n_mode;
    t_lanes      r_lanes, n_lanes;
    logic [3:0]  r_round, n_round;
    logic [3:0]  r_len, n_len;
    logic        r_open, n_open;
    logic [63:0] r_key_high, r_key_low;
    t_out_word   r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_lanes      w_round_lanes;
    logic        w_in_acc;
    logic        w_out_free;
    logic [3:0]  w_len;

    asc_round u_round (
        .i_lanes (r_lanes),
        .i_round (r_round),
        .o_lanes (w_round_lanes)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_len      = (i_data.block_bytes > BLOCK_BYTES) ? BLOCK_BYTES
                                                           : i_data.block_bytes;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Sequencer: absorb, emit, run rounds, emit tag
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_lanes     = r_lanes;
        n_round     = r_round;
        n_len       = r_len;
        n_open      = r_open;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_data.kind == KIND_START) begin
                        n_lanes[0] = ASCON_IV;
                        n_lanes[1] = r_key_high;
                        n_lanes[2] = r_key_low;
                        n_lanes[3] = i_data.nonce_high;
                        n_lanes[4] = i_data.nonce_low;
                        n_round    = '0;
                        n_mode     = MODE_INIT;
                        n_open     = 1'b1;
                        n_state    = S_PERM;
                    end else if (r_open) begin
                        n_len = w_len;
                        if (w_len == BLOCK_BYTES) begin
                            n_lanes[0] = r_lanes[0] ^ i_data.block;
                            n_mode     = MODE_BLOCK;
                        end else begin
                            n_lanes[0] = r_lanes[0] ^ (i_data.block & asc_mask(w_len))
                                         ^ asc_pad(w_len);
                            n_lanes[1] = r_lanes[1] ^ r_key_high;
                            n_lanes[2] = r_lanes[2] ^ r_key_low;
                            n_mode     = MODE_FINAL;
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.out_kind   = OUT_CT;
                    n_out.data       = r_lanes[0] & asc_mask(r_len);
                    n_out.data_bytes = r_len;
                    n_out.last       = 1'b0;
                    n_out_valid      = 1'b1;
                    n_round          = (r_mode == MODE_BLOCK) ? FIRST_BLOCK : 4'd0;
                    n_state          = S_PERM;
                end
            end
            S_PERM: begin
                n_lanes = w_round_lanes;
                n_round = r_round + 4'd1;
                if (r_round == LAST_ROUND) begin
                    unique case (r_mode)
                        MODE_INIT: begin
                            n_lanes[3] = w_round_lanes[3] ^ r_key_high;
                            n_lanes[4] = w_round_lanes[4] ^ r_key_low ^ 64'd1;
                            n_state    = S_IDLE;
                        end
                        MODE_FINAL: begin
                            n_lanes[3] = w_round_lanes[3] ^ r_key_high;
                            n_lanes[4] = w_round_lanes[4] ^ r_key_low;
                            n_state    = S_TAG0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TAG0: begin
                if (w_out_free) begin
                    n_out.out_kind   = OUT_TAG;
                    n_out.data       = r_lanes[3];
                    n_out.data_bytes = BLOCK_BYTES;
                    n_out.last       = 1'b0;
                    n_out_valid      = 1'b1;
                    n_state          = S_TAG1;
                end
            end
            S_TAG1: begin
                if (w_out_free) begin
                    n_out.out_kind   = OUT_TAG;
                    n_out.data       = r_lanes[4];
                    n_out.data_bytes = BLOCK_BYTES;
                    n_out.last       = 1'b1;
                    n_out_valid      = 1'b1;
                    n_open           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_INIT;
            r_round     <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_round     <= n_round;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold lanes, block length and output word
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_len   <= n_len;
        r_out   <= n_out;
    end

    // Take key writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default:      r_key_high <= r_key_high;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/asc_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One round of the Ascon permutation: constant, S-box layer, linear layer
module asc_round
    import asc_pkg::*;
(
    input  wire t_lanes     i_lanes,
    input  wire logic [3:0] i_round,
    output t_lanes          o_lanes
);

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    logic [7:0]  w_rc;
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] b0, b1, b2, b3, b4;
    logic [63:0] c0, c1, c2, c3, c4;

    // Round constant: high nibble counts down, low nibble counts up
    assign w_rc = {4'hF - i_round, i_round};

    // Add constant and run the bit-sliced S-box
    always_comb begin
        a0 = i_lanes[0] ^ i_lanes[4];
        a4 = i_lanes[4] ^ i_lanes[3];
        a2 = i_lanes[2] ^ {56'd0, w_rc} ^ i_lanes[1];
        a1 = i_lanes[1];
        a3 = i_lanes[3];
        b0 = a0 ^ (~a1 & a2);
        b1 = a1 ^ (~a2 & a3);
        b2 = a2 ^ (~a3 & a4);
        b3 = a3 ^ (~a4 & a0);
        b4 = a4 ^ (~a0 & a1);
        c1 = b1 ^ b0;
        c0 = b0 ^ b4;
        c3 = b3 ^ b2;
        c2 = ~b2;
        c4 = b4;
    end

    // Linear diffusion per lane
    assign o_lanes[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
    assign o_lanes[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
    assign o_lanes[2] = c2 ^ rotr(c2, 1)  ^ rotr(c2, 6);
    assign o_lanes[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
    assign o_lanes[4] = c4 ^ rotr(c4, 7)  ^ rotr(c4, 41);

endmodule

`default_nettype wire

// ===== design/asc_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the output word stream
module asc_chk
    import asc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_valid,
    input wire logic      i_stall,
    input wire t_out_word o_data
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output word changed while stalled");

    // The last word is always a full tag word
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.out_kind == OUT_TAG
                                   && o_data.data_bytes == BLOCK_BYTES)
        else $error("last flag on a non-tag word");

    // Tag words carry eight bytes
    a_tag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind == OUT_TAG |-> o_data.data_bytes == BLOCK_BYTES)
        else $error("tag word not eight bytes");

    // Ciphertext bytes past the length are zero and the word is never last
    a_ct_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_kind == OUT_CT |->
            o_data.data_bytes <= BLOCK_BYTES && !o_data.last
            && (o_data.data & ~asc_mask(o_data.data_bytes)) == 64'd0)
        else $error("ciphertext word has stray bytes");

endmodule

bind ascon128_aead_encrypt asc_chk u_asc_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// ===== tb/sv/ascon_enc_checker.sv =====
`timescale 1ns / 1ps

// Watch the key port and both word channels, predict ciphertext and tag
// words from the accepted input words, and compare them in order.
module ascon_enc_checker
    import asc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] perm_state [5];
    logic        msg_open;
    t_out_word   ct_tag_queue [$];
    t_out_word   want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // Run permutation rounds from the given round index up to the last one
    function automatic void run_rounds(input int unsigned first);
        logic [63:0] t0, t1, t2, t3, t4;
        logic [63:0] s0, s1, s2, s3, s4;
        logic [3:0]  rn;
        for (int unsigned r = first; r < ROUNDS_A; r++) begin
            rn = 4'(r);
            perm_state[2] = perm_state[2] ^ 64'({4'hf - rn, rn});
            t0 = perm_state[0] ^ perm_state[4];
            t4 = perm_state[4] ^ perm_state[3];
            t2 = perm_state[2] ^ perm_state[1];
            t1 = perm_state[1];
            t3 = perm_state[3];
            // nonlinear layer
            s0 = t0 ^ (~t1 & t2);
            s1 = t1 ^ (~t2 & t3);
            s2 = t2 ^ (~t3 & t4);
            s3 = t3 ^ (~t4 & t0);
            s4 = t4 ^ (~t0 & t1);
            s1 = s1 ^ s0;
            s0 = s0 ^ s4;
            s3 = s3 ^ s2;
            s2 = ~s2;
            // linear diffusion per lane
            perm_state[0] = s0 ^ ror64(s0, 19) ^ ror64(s0, 28);
            perm_state[1] = s1 ^ ror64(s1, 61) ^ ror64(s1, 39);
            perm_state[2] = s2 ^ ror64(s2, 1) ^ ror64(s2, 6);
            perm_state[3] = s3 ^ ror64(s3, 10) ^ ror64(s3, 17);
            perm_state[4] = s4 ^ ror64(s4, 7) ^ ror64(s4, 41);
        end
    endfunction

    function automatic void queue_word(input t_out_kind k, input logic [63:0] d,
                                       input logic [3:0] nb, input logic lst);
        t_out_word w;
        w.out_kind   = k;
        w.data       = d;
        w.data_bytes = nb;
        w.last       = lst;
        ct_tag_queue.push_back(w);
    endfunction

    // Advance the cipher state for one accepted input word
    function automatic void predict_encrypt(input t_in_word w);
        logic [3:0]  nb;
        logic [63:0] keep;
        logic [63:0] pad;
        if (w.kind == KIND_START) begin
            perm_state[0] = ASCON_IV;
            perm_state[1] = key_hi;
            perm_state[2] = key_lo;
            perm_state[3] = w.nonce_high;
            perm_state[4] = w.nonce_low;
            run_rounds(0);
            perm_state[3] = perm_state[3] ^ key_hi;
            perm_state[4] = perm_state[4] ^ key_lo ^ 64'd1;
            msg_open = 1'b1;
        end else if (msg_open) begin
            nb = (w.block_bytes > BLOCK_BYTES) ? BLOCK_BYTES : w.block_bytes;
            if (nb == BLOCK_BYTES) begin
                perm_state[0] = perm_state[0] ^ w.block;
                queue_word(OUT_CT, perm_state[0], BLOCK_BYTES, 1'b0);
                run_rounds(ROUNDS_A - ROUNDS_B);
            end else begin
                // final block: pad, emit, then finalize for the tag
                keep = (nb == 4'd0) ? 64'd0 : ({64{1'b1}} << (64 - 8 * nb));
                pad  = 64'(PAD_BYTE) << (56 - 8 * nb);
                perm_state[0] = perm_state[0] ^ (w.block & keep) ^ pad;
                queue_word(OUT_CT, perm_state[0] & keep, nb, 1'b0);
                perm_state[1] = perm_state[1] ^ key_hi;
                perm_state[2] = perm_state[2] ^ key_lo;
                run_rounds(0);
                perm_state[3] = perm_state[3] ^ key_hi;
                perm_state[4] = perm_state[4] ^ key_lo;
                queue_word(OUT_TAG, perm_state[3], BLOCK_BYTES, 1'b0);
                queue_word(OUT_TAG, perm_state[4], BLOCK_BYTES, 1'b1);
                msg_open = 1'b0;
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                          input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    // Track key writes, check output words, then predict from input words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hi   = '0;
            key_lo   = '0;
            msg_open = 1'b0;
            for (int i = 0; i < 5; i++) perm_state[i] = '0;
            ct_tag_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_KEY_HIGH) key_hi = i_cfg_wdata;
                else key_lo = i_cfg_wdata;
            end
            if (i_out_valid && !i_out_stall) begin
                if (ct_tag_queue.size() == 0) begin
                    $error("output word with nothing expected: %h", i_out_word);
                    o_fail_count++;
                end else begin
                    want = ct_tag_queue.pop_front();
                    compare_field("out_kind", 64'(want.out_kind), 64'(i_out_word.out_kind));
                    compare_field("data", want.data, i_out_word.data);
                    compare_field("data_bytes", 64'(want.data_bytes),
                                  64'(i_out_word.data_bytes));
                    compare_field("last", 64'(want.last), 64'(i_out_word.last));
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) predict_encrypt(i_in_word);
        end
        o_pending = ct_tag_queue.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import asc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_WORDS   = 55;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_word   o_data;

    int fail_count;
    int pending;
    int checked;

    int       counted = 0;
    int       key_sets = 0;
    int       burst_left = 0;
    int       tx_gap_max = 0;
    t_rx_mode rx_mode = RX_FREE;
    int       hold_req = 0;
    int       hold_ack = 0;
    int       hold_left = 0;
    int       rx_cycle = 0;

    ascon128_aead_encrypt i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    ascon_enc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_word    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_word   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver stall: a long hold-off when asked, otherwise the current pattern
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FREE:     i_stall <= 1'b0;
                RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                default:     i_stall <= ((rx_cycle % 7) < 3);
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_word start_word(input logic [63:0] nh, input logic [63:0] nl);
        t_in_word w;
        w.kind        = KIND_START;
        w.nonce_high  = nh;
        w.nonce_low   = nl;
        w.block       = rand64();
        w.block_bytes = 4'($urandom_range(0, 15));
        return w;
    endfunction

    function automatic t_in_word block_word(input logic [63:0] d, input logic [3:0] nb);
        t_in_word w;
        w.kind        = KIND_BLOCK;
        w.nonce_high  = rand64();
        w.nonce_low   = rand64();
        w.block       = d;
        w.block_bytes = nb;
        return w;
    endfunction

    // Offer one word, holding it until the block takes it
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Send in bursts with random gaps between them
    task automatic offer(input t_in_word w, input bit counts);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (tx_gap_max > 0) idle_for($urandom_range(0, tx_gap_max));
        end
        burst_left--;
        send_word(w);
        if (counts) counted++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_KEY_HIGH;
        i_cfg_wdata <= hi;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_KEY_LOW;
        i_cfg_wdata <= lo;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        key_sets++;
    endtask

    task automatic full_blocks(input int n);
        repeat (n) begin
            offer(block_word(rand64(),
                  ($urandom_range(0, 11) == 0) ? 4'($urandom_range(9, 15)) : BLOCK_BYTES), 1);
        end
    endtask

    task automatic encrypt_message(input int nfull);
        offer(start_word(rand64(), rand64()), 1);
        full_blocks(nfull);
        offer(block_word(rand64(), 4'($urandom_range(0, 7))), 1);
    endtask

    // Mostly complete messages, some stray blocks and abandoned messages
    task automatic random_traffic(input int words);
        int target;
        int pick;
        int nfull;
        target = counted + words;
        while (counted < target) begin
            if ($urandom_range(0, 3) == 0) begin
                rx_mode    = t_rx_mode'($urandom_range(0, 3));
                tx_gap_max = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            end
            pick  = $urandom_range(0, 99);
            nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            if (pick < 75) begin
                encrypt_message(nfull);
            end else if (pick < 87) begin
                offer(block_word(rand64(), 4'($urandom_range(0, 15))), 0);
            end else begin
                offer(start_word(rand64(), rand64()), 1);
                full_blocks(nfull);
            end
        end
    endtask

    initial begin
        #2_500_000;
        $display("FAIL ascon128_aead_encrypt");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_KEY_HIGH;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_data      = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset key, no idling on either side
        offer(block_word(rand64(), 4'd3), 0);
        offer(start_word(64'd0, 64'd0), 1);
        offer(block_word(64'd0, 4'd0), 1);
        offer(block_word({64{1'b1}}, BLOCK_BYTES), 0);
        offer(start_word({64{1'b1}}, {64{1'b1}}), 1);
        offer(block_word({64{1'b1}}, BLOCK_BYTES), 1);
        offer(block_word(64'd0, BLOCK_BYTES), 1);
        offer(block_word({64{1'b1}}, 4'd7), 1);
        offer(start_word(64'd0, {64{1'b1}}), 1);
        offer(block_word({$urandom, $urandom}, 4'd9), 1);
        offer(block_word({64{1'b1}}, 4'd15), 1);
        offer(block_word({64{1'b1}}, 4'd1), 1);
        offer(start_word({$urandom, $urandom}, {$urandom, $urandom}), 1);
        offer(start_word({$urandom, $urandom}, {$urandom, $urandom}), 1);
        offer(block_word({$urandom, $urandom}, BLOCK_BYTES), 1);
        offer(block_word({$urandom, $urandom}, 4'd4), 1);
        offer(start_word({64{1'b1}}, 64'd0), 1);
        offer(block_word({$urandom, $urandom}, 4'd5), 1);
        offer(start_word({$urandom, $urandom}, {$urandom, $urandom}), 1);
        offer(block_word({$urandom, $urandom}, 4'd6), 1);
        offer(start_word({$urandom, $urandom}, {$urandom, $urandom}), 1);
        offer(block_word({$urandom, $urandom}, 4'd2), 1);
        drain_results();

        // All-ones key, light stalls and bursts
        set_key({64{1'b1}}, {64{1'b1}});
        rx_mode    = RX_LIGHT;
        tx_gap_max = 4;
        random_traffic(PHASE_WORDS);
        drain_results();

        // Random key; hold the output off while long messages keep coming
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        rx_mode    = RX_HEAVY;
        tx_gap_max = 0;
        hold_req++;
        encrypt_message(6);
        encrypt_message(2);
        random_traffic(PHASE_WORDS);
        drain_results();

        // Mixed-extreme key
        set_key(64'd0, {64{1'b1}});
        rx_mode = RX_PERIODIC;
        random_traffic(PHASE_WORDS);
        drain_results();

        set_key({$urandom, $urandom}, 64'd0);
        random_traffic(PHASE_WORDS);
        drain_results();

        $display("Covered %0d input words under %0d written keys plus the reset key,",
                 counted, key_sets);
        $display("with %0d ciphertext and tag words compared.", checked);
        if (fail_count == 0) begin
            $display("PASS ascon128_aead_encrypt");
        end else begin
            $display("FAIL ascon128_aead_encrypt");
        end
        $finish;
    end

endmodule
